// ----- hdl/qslerp_pkg.sv -----
// Shared types and constants for the quaternion slerp pipeline.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
package qslerp_pkg;

  // Field widths
  localparam int COMP_WIDTH = 16;   // signed Q2.14 component
  localparam int T_WIDTH    = 17;   // unsigned Q0.16 fraction, 1.0 included
  localparam int THR_WIDTH  = 28;   // near_threshold register
  localparam int WT_WIDTH   = 29;   // Q28 weight, 1.0 included

  // Datapath widths
  localparam int CW         = 32;   // CORDIC x, y, z
  localparam int SQ_W       = 58;   // square root radicand and root register
  localparam int SQRT_STEPS = 28;   // one root bit per step
  localparam int DIV_W      = 30;   // divider remainder and divisor
  localparam int DIV_STEPS  = 28;   // one quotient bit per step

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 2'd1;

  localparam logic [THR_WIDTH-1:0] NEAR_THRESHOLD_RST = 28'd256;
  localparam logic [WT_WIDTH-1:0]  ONE_Q28            = 29'h1000_0000;
  localparam logic [T_WIDTH-1:0]   T_ONE              = 17'h1_0000;

  // atan(2^-i) in Q28 radians
  localparam logic [28:0] ATAN_Q28 [32] = '{
    29'd210828714, 29'd124459457, 29'd65760959, 29'd33381290, 29'd16755422,
    29'd8385879,   29'd4193963,   29'd2097109,  29'd1048571,  29'd524287,
    29'd262144,    29'd131072,    29'd65536,    29'd32768,    29'd16384,
    29'd8192,      29'd4096,      29'd2048,     29'd1024,     29'd512,
    29'd256,       29'd128,       29'd64,       29'd32,       29'd16,
    29'd8,         29'd4,         29'd2,        29'd1,        29'd0,
    29'd0,         29'd0
  };

  // Per-request information that travels alongside the arithmetic cells
  typedef struct packed {
    logic                             vld;
    logic                             lin;
    logic                             flip;
    logic [1:0]                       wzero;  // spherical weight clamps to 0
    logic [1:0]                       wfull;  // spherical weight clamps to 1.0
    logic [T_WIDTH-1:0]               t;
    logic [WT_WIDTH-1:0]              dot;
    logic [3:0][COMP_WIDTH-1:0]       f;
    logic [3:0][COMP_WIDTH:0]         g;      // one bit wider: negated -2.0 kept
  } side_t;

endpackage

// ----- hdl/quaternion_slerp_top.sv -----
// Quaternion slerp top level: dot product, square root, CORDIC and divider cell chains.
// Depends on qslerp_pkg, qslerp_sqrt_cell, qslerp_cordic_cell and qslerp_div_cell.

// Fully pipelined: one request is taken every clock and one result leaves every
// clock while out_ready_i is high. Requests pass through the 28-cell square root
// chain, the vectoring and rotation CORDIC chains of ANGLE_ITERATIONS cells each
// and the 28-cell divider chain. A low out_ready_i with a result waiting freezes
// the whole pipeline. Configuration writes take effect on requests that reach the
// stage B linear decision after the write.
module quaternion_slerp_top #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [qslerp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [qslerp_pkg::THR_WIDTH-1:0]     cfg_wdata_i,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [qslerp_pkg::COMP_WIDTH-1:0] from_x_i,
  input  logic signed [qslerp_pkg::COMP_WIDTH-1:0] from_y_i,
  input  logic signed [qslerp_pkg::COMP_WIDTH-1:0] from_z_i,
  input  logic signed [qslerp_pkg::COMP_WIDTH-1:0] from_w_i,
  input  logic signed [qslerp_pkg::COMP_WIDTH-1:0] to_x_i,
  input  logic signed [qslerp_pkg::COMP_WIDTH-1:0] to_y_i,
  input  logic signed [qslerp_pkg::COMP_WIDTH-1:0] to_z_i,
  input  logic signed [qslerp_pkg::COMP_WIDTH-1:0] to_w_i,
  input  logic [qslerp_pkg::T_WIDTH-1:0]       t_frac_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [qslerp_pkg::COMP_WIDTH-1:0] out_x_o,
  output logic signed [qslerp_pkg::COMP_WIDTH-1:0] out_y_o,
  output logic signed [qslerp_pkg::COMP_WIDTH-1:0] out_z_o,
  output logic signed [qslerp_pkg::COMP_WIDTH-1:0] out_w_o,
  output logic                                 used_linear_o,
  output logic                                 target_flipped_o
);

  localparam int CWD  = qslerp_pkg::COMP_WIDTH;
  localparam int TW   = qslerp_pkg::T_WIDTH;
  localparam int WW   = qslerp_pkg::WT_WIDTH;
  localparam int CW   = qslerp_pkg::CW;
  localparam int SQW  = qslerp_pkg::SQ_W;
  localparam int DW   = qslerp_pkg::DIV_W;
  localparam int NSQ  = qslerp_pkg::SQRT_STEPS;
  localparam int NDV  = qslerp_pkg::DIV_STEPS;
  localparam int NA   = ANGLE_ITERATIONS;
  localparam int DOTW = 2 * CWD + 3;      // four-term sum of products
  localparam int PFW  = WW + 1 + CWD;     // weight times source component
  localparam int PGW  = WW + 2 + CWD;     // weight times target component
  localparam int ACCW = PGW + 1;
  localparam int PAW  = TW + 1 + CW;      // fraction times angle

  // side line positions (index of the register after each stage)
  localparam int P_A    = 0;
  localparam int P_B    = 1;
  localparam int P_C    = 2;
  localparam int P_SQ   = P_C + NSQ;
  localparam int P_VEC  = P_SQ + NA;
  localparam int P_D    = P_VEC + 1;
  localparam int P_ROT  = P_D + NA;
  localparam int P_E    = P_ROT + 1;
  localparam int P_DIV  = P_E + NDV;
  localparam int P_F    = P_DIV + 1;
  localparam int P_G    = P_F + 1;
  localparam int SIDE_LEN = P_G + 1;

  // configuration registers
  logic                             mode_q;
  logic [qslerp_pkg::THR_WIDTH-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      thr_q  <= qslerp_pkg::NEAR_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        qslerp_pkg::REG_INTERP_MODE:    mode_q <= cfg_wdata_i[0];
        qslerp_pkg::REG_NEAR_THRESHOLD: thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // global advance: output register empty or being drained
  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  qslerp_pkg::side_t side_q [SIDE_LEN];
  qslerp_pkg::side_t side_d [SIDE_LEN];
  qslerp_pkg::side_t side_in;

  // stage A: capture request, clamp fraction, component products
  logic signed [CWD-1:0]   fin [4];
  logic signed [CWD-1:0]   gin [4];
  logic signed [2*CWD-1:0] prod_d [4];
  logic signed [2*CWD-1:0] prod_q [4];

  assign fin[0] = from_x_i;
  assign fin[1] = from_y_i;
  assign fin[2] = from_z_i;
  assign fin[3] = from_w_i;
  assign gin[0] = to_x_i;
  assign gin[1] = to_y_i;
  assign gin[2] = to_z_i;
  assign gin[3] = to_w_i;

  always_comb begin
    side_in       = '0;
    side_in.vld   = in_valid_i;
    side_in.t     = (t_frac_i > qslerp_pkg::T_ONE) ? qslerp_pkg::T_ONE : t_frac_i;
    for (int k = 0; k < 4; k++) begin
      side_in.f[k] = fin[k];
      side_in.g[k] = {gin[k][CWD-1], gin[k]};
      prod_d[k]    = fin[k] * gin[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= prod_d[k];
      end
    end
  end

  // stage B: dot product, sign fold, linear decision
  logic signed [DOTW-1:0] dot_sum, dot_abs;
  logic signed [DOTW:0]   gap;
  logic                   flip_b, lin_b;

  always_comb begin
    dot_sum = '0;
    for (int k = 0; k < 4; k++) begin
      dot_sum = dot_sum + DOTW'(prod_q[k]);
    end
    flip_b  = dot_sum[DOTW-1];
    dot_abs = flip_b ? -dot_sum : dot_sum;
    gap     = $signed((DOTW+1)'(qslerp_pkg::ONE_Q28)) - $signed({1'b0, dot_abs});
    lin_b   = mode_q || (gap <= $signed((DOTW+1)'(thr_q)));
  end

  // stage C: radicand (1 - dot)(1 + dot)
  logic [WW-1:0]  rad_a, rad_b;
  logic [SQW-1:0] sq_q;

  assign rad_a = qslerp_pkg::ONE_Q28 - side_q[P_B].dot;
  assign rad_b = qslerp_pkg::ONE_Q28 + side_q[P_B].dot;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q <= rad_a * rad_b;
    end
  end

  // square root chain
  logic [SQW-1:0] sv [NSQ+1];
  logic [SQW-1:0] sr [NSQ+1];

  assign sv[0] = sq_q;
  assign sr[0] = '0;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    qslerp_sqrt_cell #(.STEP(k)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .v_i   (sv[k]),
      .r_i   (sr[k]),
      .v_o   (sv[k+1]),
      .r_o   (sr[k+1])
    );
  end

  // vectoring chain: omega = acos(dot)
  logic signed [CW-1:0] vx [NA+1];
  logic signed [CW-1:0] vy [NA+1];
  logic signed [CW-1:0] vz [NA+1];

  assign vx[0] = $signed(CW'(side_q[P_SQ].dot));
  assign vy[0] = $signed(CW'(sr[NSQ][WW-1:0]));
  assign vz[0] = '0;

  for (genvar i = 0; i < NA; i++) begin : g_vec
    qslerp_cordic_cell #(.STEP(i), .VECTORING(1'b1)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (vx[i]),
      .y_i   (vy[i]),
      .z_i   (vz[i]),
      .x_o   (vx[i+1]),
      .y_o   (vy[i+1]),
      .z_o   (vz[i+1])
    );
  end

  // stage D: blend angles (1-t) omega and t omega
  logic [TW-1:0]         tw0;
  logic signed [PAW-1:0] pa0, pa1;
  logic signed [CW-1:0]  om_q, a0_q, a1_q;

  assign tw0 = qslerp_pkg::T_ONE - side_q[P_VEC].t;
  assign pa0 = $signed({1'b0, tw0}) * vz[NA];
  assign pa1 = $signed({1'b0, side_q[P_VEC].t}) * vz[NA];

  always_ff @(posedge clk_i) begin
    if (en) begin
      om_q <= vz[NA];
      a0_q <= pa0[CW+15:16];
      a1_q <= pa1[CW+15:16];
    end
  end

  // rotation lanes: sin(omega), sin(a0), sin(a1)
  logic signed [CW-1:0] rx [3][NA+1];
  logic signed [CW-1:0] ry [3][NA+1];
  logic signed [CW-1:0] rz [3][NA+1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign rx[l][0] = $signed(CW'(qslerp_pkg::ONE_Q28));
    assign ry[l][0] = '0;
    for (genvar i = 0; i < NA; i++) begin : g_rot
      qslerp_cordic_cell #(.STEP(i), .VECTORING(1'b0)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (rx[l][i]),
        .y_i   (ry[l][i]),
        .z_i   (rz[l][i]),
        .x_o   (rx[l][i+1]),
        .y_o   (ry[l][i+1]),
        .z_o   (rz[l][i+1])
      );
    end
  end

  assign rz[0][0] = om_q;
  assign rz[1][0] = a0_q;
  assign rz[2][0] = a1_q;

  // stage E: divider set-up, clamp flags, vanishing sine
  logic signed [CW-1:0] sg;
  logic [DW-1:0]        dvs_q;
  logic [DW-1:0]        rem_q [2];

  assign sg = ry[0][NA];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvs_q    <= sg[DW-1:0];
      rem_q[0] <= ry[1][NA][DW-1:0];
      rem_q[1] <= ry[2][NA][DW-1:0];
    end
  end

  // divider lanes for the two spherical weights
  logic [DW-1:0]  dd [2][NDV+1];
  logic [DW-1:0]  dr [2][NDV+1];
  logic [NDV-1:0] dq [2][NDV+1];

  for (genvar l = 0; l < 2; l++) begin : g_div
    assign dd[l][0] = dvs_q;
    assign dr[l][0] = rem_q[l];
    assign dq[l][0] = '0;
    for (genvar k = 0; k < NDV; k++) begin : g_bit
      qslerp_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (dd[l][k]),
        .r_i   (dr[l][k]),
        .q_i   (dq[l][k]),
        .d_o   (dd[l][k+1]),
        .r_o   (dr[l][k+1]),
        .q_o   (dq[l][k+1])
      );
    end
  end

  // stage F: final weights
  logic [WW-1:0] w_sph [2];
  logic [WW-1:0] w0_d, w1_d, w0_q, w1_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (side_q[P_DIV].wzero[l]) begin
        w_sph[l] = '0;
      end else if (side_q[P_DIV].wfull[l]) begin
        w_sph[l] = qslerp_pkg::ONE_Q28;
      end else begin
        w_sph[l] = {1'b0, dq[l][NDV]};
      end
    end
    if (side_q[P_DIV].lin) begin
      w0_d = {qslerp_pkg::T_ONE - side_q[P_DIV].t, 12'b0};
      w1_d = {side_q[P_DIV].t, 12'b0};
    end else begin
      w0_d = w_sph[0];
      w1_d = w_sph[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w0_q <= w0_d;
      w1_q <= w1_d;
    end
  end

  // stage G: weighted components
  logic signed [PFW-1:0] pf_q [4];
  logic signed [PGW-1:0] pg_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        pf_q[k] <= $signed({1'b0, w0_q}) * $signed(side_q[P_F].f[k]);
        pg_q[k] <= $signed({1'b0, w1_q}) * $signed(side_q[P_F].g[k]);
      end
    end
  end

  // stage H: sum, round half up, saturate
  logic signed [ACCW-1:0] acc [4];
  logic signed [ACCW-1:0] shr [4];
  logic signed [CWD-1:0]  res [4];
  logic signed [CWD-1:0]  out_q [4];
  logic                   lin_q, flip_q;

  localparam logic signed [ACCW-1:0] HALF   = ACCW'(1) <<< 27;
  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'((1 << (CWD - 1)) - 1);
  localparam logic signed [ACCW-1:0] SAT_LO = -(ACCW'(1) <<< (CWD - 1));

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc[k] = ACCW'(pf_q[k]) + ACCW'(pg_q[k]) + HALF;
      shr[k] = acc[k] >>> 28;
      if (shr[k] > SAT_HI) begin
        res[k] = SAT_HI[CWD-1:0];
      end else if (shr[k] < SAT_LO) begin
        res[k] = SAT_LO[CWD-1:0];
      end else begin
        res[k] = shr[k][CWD-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= side_q[P_G].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        out_q[k] <= res[k];
      end
      lin_q  <= side_q[P_G].lin;
      flip_q <= side_q[P_G].flip;
    end
  end

  // side line with the updates made at stages B and E
  always_comb begin
    side_d[P_A] = side_in;
    for (int n = 1; n < SIDE_LEN; n++) begin
      side_d[n] = side_q[n-1];
    end
    side_d[P_B].flip = flip_b;
    side_d[P_B].lin  = lin_b;
    side_d[P_B].dot  = dot_abs[WW-1:0];
    for (int k = 0; k < 4; k++) begin
      side_d[P_B].g[k] = flip_b ? -side_q[P_A].g[k] : side_q[P_A].g[k];
    end
    side_d[P_E].lin      = side_q[P_ROT].lin || !(sg > 0);
    side_d[P_E].wzero[0] = ry[1][NA] < 0;
    side_d[P_E].wzero[1] = ry[2][NA] < 0;
    side_d[P_E].wfull[0] = ry[1][NA] >= sg;
    side_d[P_E].wfull[1] = ry[2][NA] >= sg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < SIDE_LEN; n++) begin
        side_q[n] <= '0;
      end
    end else if (en) begin
      for (int n = 0; n < SIDE_LEN; n++) begin
        side_q[n] <= side_d[n];
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_x_o          = out_q[0];
  assign out_y_o          = out_q[1];
  assign out_z_o          = out_q[2];
  assign out_w_o          = out_q[3];
  assign used_linear_o    = lin_q;
  assign target_flipped_o = flip_q;

  // a stalled pipeline holds its weights
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && side_q[P_F].vld |=> $stable(w0_q) && $stable(w1_q))
    else $error("weights changed during a stall");

  // weights never exceed 1.0
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_q[P_F].vld |-> (w0_q <= qslerp_pkg::ONE_Q28) && (w1_q <= qslerp_pkg::ONE_Q28))
    else $error("blend weight above one");

  // linear weights add up to exactly 1.0
  a_linear_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_q[P_F].vld && side_q[P_F].lin |->
      (({1'b0, w0_q} + {1'b0, w1_q}) == {1'b0, qslerp_pkg::ONE_Q28}))
    else $error("linear weights do not sum to one");

endmodule

// ----- hdl/qslerp_sqrt_cell.sv -----
// One bit step of the integer square root chain.
// Depends on qslerp_pkg for the radicand width and step count.
module qslerp_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [qslerp_pkg::SQ_W-1:0] v_i,
  input  logic [qslerp_pkg::SQ_W-1:0] r_i,
  output logic [qslerp_pkg::SQ_W-1:0] v_o,
  output logic [qslerp_pkg::SQ_W-1:0] r_o
);

  localparam int W     = qslerp_pkg::SQ_W;
  localparam int SHIFT = 2 * (qslerp_pkg::SQRT_STEPS - 1 - STEP);
  localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << SHIFT;

  logic [W-1:0] trial;
  logic [W-1:0] v_d, r_d, v_q, r_q;

  // try the next root bit
  always_comb begin
    trial = r_i + BIT;
    if (v_i >= trial) begin
      v_d = v_i - trial;
      r_d = (r_i >> 1) + BIT;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
      r_q <= r_d;
    end
  end

  assign v_o = v_q;
  assign r_o = r_q;

endmodule

// ----- hdl/qslerp_cordic_cell.sv -----
// One micro-rotation of a CORDIC chain, vectoring or rotation mode.
// Depends on qslerp_pkg for the datapath width and the arctangent table.
module qslerp_cordic_cell #(
  parameter int STEP      = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [qslerp_pkg::CW-1:0] x_i,
  input  logic signed [qslerp_pkg::CW-1:0] y_i,
  input  logic signed [qslerp_pkg::CW-1:0] z_i,
  output logic signed [qslerp_pkg::CW-1:0] x_o,
  output logic signed [qslerp_pkg::CW-1:0] y_o,
  output logic signed [qslerp_pkg::CW-1:0] z_o
);

  localparam int W = qslerp_pkg::CW;

  logic signed [W-1:0] dx, dy, ang;
  logic signed [W-1:0] x_d, y_d, z_d, x_q, y_q, z_q;
  logic                ccw;

  assign ang = $signed(W'(qslerp_pkg::ATAN_Q28[STEP]));
  assign dx  = y_i >>> STEP;
  assign dy  = x_i >>> STEP;

  // vectoring drives y to zero, rotation drives z to zero
  always_comb begin
    if (VECTORING) begin
      ccw = !(y_i > 0);
    end else begin
      ccw = (z_i >= 0);
    end
    if (ccw) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ang;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ----- hdl/qslerp_div_cell.sv -----
// One quotient bit of the restoring divider chain for the spherical weights.
// Depends on qslerp_pkg for remainder and quotient widths.
module qslerp_div_cell (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [qslerp_pkg::DIV_W-1:0]     d_i,
  input  logic [qslerp_pkg::DIV_W-1:0]     r_i,
  input  logic [qslerp_pkg::DIV_STEPS-1:0] q_i,
  output logic [qslerp_pkg::DIV_W-1:0]     d_o,
  output logic [qslerp_pkg::DIV_W-1:0]     r_o,
  output logic [qslerp_pkg::DIV_STEPS-1:0] q_o
);

  localparam int W = qslerp_pkg::DIV_W;
  localparam int Q = qslerp_pkg::DIV_STEPS;

  logic [W-1:0] r2, r_d, d_q, r_q;
  logic [Q-1:0] q_d, q_q;
  logic         ge;

  // remainder stays below the divisor, so doubling never overflows
  always_comb begin
    r2  = {r_i[W-2:0], 1'b0};
    ge  = (r2 >= d_i);
    r_d = ge ? (r2 - d_i) : r2;
    q_d = {q_i[Q-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_i;
      r_q <= r_d;
      q_q <= q_d;
    end
  end

  assign d_o = d_q;
  assign r_o = r_q;
  assign q_o = q_q;

endmodule
